### rtl/morse_key_timing_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// Morse key timing decoder assertion macros
// Clocked on clk and disabled during reset; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef MORSE_KEY_TIMING_DECODER_CORE_MACROS_SVH
`define MORSE_KEY_TIMING_DECODER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// An invariant that must hold at every clock edge.
`define MKTD_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant violated");
// A condition that must hold in the cycle after the trigger.
`define MKTD_ASSERT_NEXT(label, trig, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
    else $error("next-cycle check violated");
`else
`define MKTD_ASSERT(label, expr)
`define MKTD_ASSERT_NEXT(label, trig, expr)
`endif
`endif

### rtl/mktd_pkg.sv
// ----------------------------------------------------------------------------
// Morse key timing decoder package
// Sizes, register map, result codes, state types and the letter table.
// ----------------------------------------------------------------------------
package mktd_pkg;

  localparam int MAX_SYMBOLS = 8;
  localparam int TIMER_BITS  = 16;
  localparam int CFG_W       = 16;
  localparam int PRESS_W     = 16;
  localparam int CMP_W       = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
  localparam int ADDR_W      = 5;
  localparam int MAX_RES     = 3;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int NRES_W      = $clog2(MAX_RES + 1);

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
  localparam logic [PRESS_W-1:0]    PRESS_MAX = {PRESS_W{1'b1}};

  localparam logic [2:0] REG_DASH_THR   = 3'd0;
  localparam logic [2:0] REG_LETTER_GAP = 3'd1;
  localparam logic [2:0] REG_WORD_GAP   = 3'd2;
  localparam logic [2:0] REG_SENT_GAP   = 3'd3;
  localparam logic [2:0] REG_LOCKOUT    = 3'd4;

  localparam logic [CFG_W-1:0] RST_DASH_THR   = 16'd500;
  localparam logic [CFG_W-1:0] RST_LETTER_GAP = 16'd3000;
  localparam logic [CFG_W-1:0] RST_WORD_GAP   = 16'd5000;
  localparam logic [CFG_W-1:0] RST_SENT_GAP   = 16'd7000;
  localparam logic [CFG_W-1:0] RST_LOCKOUT    = 16'd50;

  localparam logic [6:0] CH_NONE  = 7'h00;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_QUERY = 7'h3F;

  typedef enum logic [2:0] {
    EV_DOT      = 3'd0,
    EV_DASH     = 3'd1,
    EV_LETTER   = 3'd2,
    EV_WORD     = 3'd3,
    EV_SENTENCE = 3'd4
  } mktd_event_t;

  typedef struct packed {
    mktd_event_t         kind;
    logic [6:0]          character;
    logic [PRESS_W-1:0]  press_ms;
    logic                last;
  } mktd_result_t;

  typedef struct packed {
    logic [CFG_W-1:0] dash_thr;
    logic [CFG_W-1:0] letter_gap;
    logic [CFG_W-1:0] word_gap;
    logic [CFG_W-1:0] sent_gap;
    logic [CFG_W-1:0] lockout;
  } mktd_cfg_t;

  typedef struct packed {
    logic                   held;
    logic [TIMER_BITS-1:0]  press;
    logic [TIMER_BITS-1:0]  idle;
    logic [TIMER_BITS-1:0]  lockout;
    logic [MAX_SYMBOLS-1:0] bits;
    logic [CNT_W-1:0]       count;
    logic                   ovf;
    logic                   armed;
    logic                   letter_done;
    logic                   word_done;
  } mktd_state_t;

  // Codes for lengths one to four, first symbol most significant, 1 = dash.
  localparam logic [6:0] CODE_TABLE [0:29] = '{
    7'h45, 7'h54,
    7'h49, 7'h41, 7'h4E, 7'h4D,
    7'h53, 7'h55, 7'h52, 7'h3F, 7'h44, 7'h4B, 7'h47, 7'h4F,
    7'h48, 7'h56, 7'h46, 7'h3F, 7'h4C, 7'h3F, 7'h50, 7'h4A,
    7'h42, 7'h3F, 7'h43, 7'h59, 7'h5A, 7'h3F, 7'h3F, 7'h3F
  };

  function automatic logic [6:0] mktd_decode(input logic [3:0] bits,
                                             input logic [2:0] len);
    logic [4:0] idx;
    idx = 5'd0;
    case (len)
      3'd1: idx = 5'd0 + 5'(bits[0]);
      3'd2: idx = 5'd2 + 5'(bits[1:0]);
      3'd3: idx = 5'd6 + 5'(bits[2:0]);
      3'd4: idx = 5'd14 + 5'(bits[3:0]);
      default: idx = 5'd0;
    endcase
    if (len == 3'd0 || len > 3'd4) begin
      return CH_QUERY;
    end
    return CODE_TABLE[idx];
  endfunction

endpackage

### rtl/mktd_step.sv
// ----------------------------------------------------------------------------
// Morse key timing decoder tick step
// Next state and the up to three result beats caused by one key sample.
// ----------------------------------------------------------------------------
module mktd_step (
  input  logic                                  key_down,
  input  mktd_pkg::mktd_cfg_t                   cfg,
  input  mktd_pkg::mktd_state_t                 state,
  output mktd_pkg::mktd_state_t                 state_nxt,
  output mktd_pkg::mktd_result_t [mktd_pkg::MAX_RES-1:0] res,
  output logic [mktd_pkg::NRES_W-1:0]           n_res
);
  import mktd_pkg::*;

  logic                  released;
  logic                  dash;
  logic                  fire_letter;
  logic                  fire_word;
  logic                  fire_sent;
  logic                  letter_done_now;
  logic [CMP_W-1:0]      idle_ext;
  logic [TIMER_BITS-1:0] lock_load;
  logic [PRESS_W-1:0]    press_sat;
  logic [6:0]            letter_ch;

  assign dash      = CMP_W'(state.press) >= CMP_W'(cfg.dash_thr);
  assign press_sat = (CMP_W'(state.press) > CMP_W'(PRESS_MAX)) ? PRESS_MAX
                                                               : PRESS_W'(state.press);
  assign lock_load = (CMP_W'(cfg.lockout) > CMP_W'(TIMER_MAX)) ? TIMER_MAX
                                                               : TIMER_BITS'(cfg.lockout);
  assign letter_ch = (state.ovf || state.count > CNT_W'(4)) ? CH_QUERY
                   : mktd_decode(state.bits[3:0], 3'(state.count));

  always_comb begin
    state_nxt = state;
    released  = 1'b0;
    if (state.lockout != '0) begin
      state_nxt.lockout = state.lockout - 1'b1;
    end else if (state.held) begin
      if (key_down) begin
        state_nxt.press = (state.press == TIMER_MAX) ? state.press : state.press + 1'b1;
      end else begin
        released              = 1'b1;
        state_nxt.held        = 1'b0;
        state_nxt.letter_done = 1'b0;
        state_nxt.word_done   = 1'b0;
        state_nxt.armed       = 1'b1;
        state_nxt.idle        = '0;
        state_nxt.lockout     = lock_load;
        if (state.count >= CNT_W'(MAX_SYMBOLS)) begin
          state_nxt.ovf = 1'b1;
        end else begin
          state_nxt.bits  = {state.bits[MAX_SYMBOLS-2:0], dash};
          state_nxt.count = state.count + CNT_W'(1);
        end
      end
    end else if (key_down) begin
      state_nxt.held  = 1'b1;
      state_nxt.press = TIMER_BITS'(1);
    end

    // The release beat itself never reaches a gap, since idle time restarts at zero.
    if (!state_nxt.held && !released) begin
      state_nxt.idle = (state.idle == TIMER_MAX) ? state.idle : state.idle + 1'b1;
    end
    idle_ext = CMP_W'(state_nxt.idle);

    fire_letter = !state_nxt.held && !released && state.armed && !state.letter_done &&
                  idle_ext > CMP_W'(cfg.letter_gap) && (state.count != '0 || state.ovf);
    letter_done_now = state.letter_done || fire_letter;
    fire_word   = !state_nxt.held && !released && state.armed && !state.word_done &&
                  letter_done_now && idle_ext > CMP_W'(cfg.word_gap);
    fire_sent   = !state_nxt.held && !released && state.armed &&
                  idle_ext > CMP_W'(cfg.sent_gap);

    if (fire_letter) begin
      state_nxt.bits        = '0;
      state_nxt.count       = '0;
      state_nxt.ovf         = 1'b0;
      state_nxt.letter_done = 1'b1;
    end
    if (fire_word) begin
      state_nxt.word_done = 1'b1;
    end
    if (fire_sent) begin
      state_nxt.armed = 1'b0;
    end
  end

  always_comb begin
    res   = '0;
    n_res = '0;
    if (released) begin
      res[0].kind     = dash ? EV_DASH : EV_DOT;
      res[0].press_ms = press_sat;
      n_res           = NRES_W'(1);
    end else begin
      if (fire_letter) begin
        res[n_res[1:0]].kind      = EV_LETTER;
        res[n_res[1:0]].character = letter_ch;
        n_res                     = n_res + NRES_W'(1);
      end
      if (fire_word) begin
        res[n_res[1:0]].kind      = EV_WORD;
        res[n_res[1:0]].character = CH_SPACE;
        n_res                     = n_res + NRES_W'(1);
      end
      if (fire_sent) begin
        res[n_res[1:0]].kind      = EV_SENTENCE;
        res[n_res[1:0]].character = CH_NONE;
        n_res                     = n_res + NRES_W'(1);
      end
    end
    for (int k = 0; k < MAX_RES; k++) begin
      res[k].last = (NRES_W'(k + 1) == n_res);
    end
  end

endmodule

### rtl/morse_key_timing_decoder_core.sv
// Results of an accepted tick beat enter the result queue and are offered in order.
// Throughput: one tick beat per cycle while each tick gives at most one result and
// out_stall stays low; a tick that ends a letter, word and sentence at once queues three beats.
// The rate is set by the four-entry result queue, which accepts a tick only with room for three.
// Reset (rst_n low, synchronous) clears the decoder state and the queue and
// loads the default timing registers.
// ----------------------------------------------------------------------------
// Morse key timing decoder core
// Times key presses per millisecond tick and emits dot, dash, letter, word
// and sentence beats through a small result queue; timing set over APB.
// ----------------------------------------------------------------------------
`include "morse_key_timing_decoder_core_macros.svh"

module morse_key_timing_decoder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_key_down,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_event_kind,
  output logic [6:0]                    out_character,
  output logic [mktd_pkg::PRESS_W-1:0]  out_press_ms,
  output logic                          out_last_of_tick,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mktd_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import mktd_pkg::*;

  mktd_cfg_t                   cfg_r, cfg_nxt;
  mktd_state_t                 state_r, state_nxt;
  mktd_result_t [MAX_RES-1:0]  res;
  logic [NRES_W-1:0]           n_res;
  mktd_result_t                fifo_r [QDEPTH];
  logic [QPTR_W-1:0]           rd_ptr_r, wr_ptr_r;
  logic [QCNT_W-1:0]           cnt_r;
  logic                        push, pop, cfg_wr;
  logic [NRES_W-1:0]           n_push;
  logic [2:0]                  reg_idx;
  mktd_result_t                head;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_DASH_THR:   cfg_nxt.dash_thr   = pwdata[CFG_W-1:0];
        REG_LETTER_GAP: cfg_nxt.letter_gap = pwdata[CFG_W-1:0];
        REG_WORD_GAP:   cfg_nxt.word_gap   = pwdata[CFG_W-1:0];
        REG_SENT_GAP:   cfg_nxt.sent_gap   = pwdata[CFG_W-1:0];
        REG_LOCKOUT:    cfg_nxt.lockout    = pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DASH_THR:   prdata = 32'(cfg_r.dash_thr);
      REG_LETTER_GAP: prdata = 32'(cfg_r.letter_gap);
      REG_WORD_GAP:   prdata = 32'(cfg_r.word_gap);
      REG_SENT_GAP:   prdata = 32'(cfg_r.sent_gap);
      REG_LOCKOUT:    prdata = 32'(cfg_r.lockout);
      default:        prdata = '0;
    endcase
  end

  mktd_step u_step (
    .key_down  (in_key_down),
    .cfg       (cfg_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .res       (res),
    .n_res     (n_res)
  );

  assign in_stall  = cnt_r > QCNT_W'(QDEPTH - MAX_RES);
  assign push      = in_valid && !in_stall;
  assign n_push    = push ? n_res : '0;
  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && !out_stall;
  assign head      = fifo_r[rd_ptr_r];

  assign out_event_kind   = head.kind;
  assign out_character    = head.character;
  assign out_press_ms     = head.press_ms;
  assign out_last_of_tick = head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dash_thr   <= RST_DASH_THR;
      cfg_r.letter_gap <= RST_LETTER_GAP;
      cfg_r.word_gap   <= RST_WORD_GAP;
      cfg_r.sent_gap   <= RST_SENT_GAP;
      cfg_r.lockout    <= RST_LOCKOUT;
      state_r          <= '0;
      rd_ptr_r         <= '0;
      wr_ptr_r         <= '0;
      cnt_r            <= '0;
    end else begin
      cfg_r    <= cfg_nxt;
      if (push) begin
        state_r <= state_nxt;
      end
      wr_ptr_r <= wr_ptr_r + QPTR_W'(n_push);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r    <= cnt_r + QCNT_W'(n_push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (NRES_W'(k) < n_push) begin
        fifo_r[wr_ptr_r + QPTR_W'(k)] <= res[k];
      end
    end
  end

  `MKTD_ASSERT(a_queue_bound, cnt_r <= QCNT_W'(QDEPTH))
  `MKTD_ASSERT(a_no_press_in_lockout, !(state_r.held && state_r.lockout != '0))
  `MKTD_ASSERT(a_word_needs_letter, !state_r.word_done || state_r.letter_done)
  `MKTD_ASSERT(a_symbol_bound, state_r.count <= CNT_W'(MAX_SYMBOLS))
  `MKTD_ASSERT_NEXT(a_release_arms, push && n_res != '0 && (res[0].kind == EV_DOT || res[0].kind == EV_DASH), state_r.armed && state_r.idle == '0)

endmodule
